@@ hdl/hash_ring_replica_lookup_unit_assert.svh @@
// Assertion macros shared by the hash ring lookup design.
`ifndef HASH_RING_REPLICA_LOOKUP_UNIT_ASSERT_SVH
`define HASH_RING_REPLICA_LOOKUP_UNIT_ASSERT_SVH
// Same-cycle implication checked on every rising clock edge outside reset.
`define HR_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HR_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ hdl/hrrl_pkg.sv @@
// Package with shared types and constants of the hash ring lookup unit.
`timescale 1ns / 1ps
`default_nettype none
package hrrl_pkg;
    localparam int RING_SLOTS_DEF   = 256;
    localparam int MAX_REPLICAS_DEF = 8;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // One classified command in the queue between front and back.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] point_hash;
        logic [31:0] node_id;
        logic [3:0]  replica_count;
    } cmd_t;
endpackage
`default_nettype wire

@@ hdl/hash_ring_replica_lookup_unit.sv @@
// Top level of the hash ring replica lookup unit.
// Insert: dequeue, read and compare each slot scanned, read and write each slot shifted, write, emit.
// Remove: dequeue, read and check each slot, with a settle state after each kept slot, then finish and emit.
// Lookup: dequeue, read and compare each slot scanned, read and check each slot walked, then pick and emit each result.
// One transaction at a time in the back end; output stalls hold it in the emit state.
// Reset clears the fill count and control; ring contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module hash_ring_replica_lookup_unit #(
    parameter int RING_SLOTS   = hrrl_pkg::RING_SLOTS_DEF,
    parameter int MAX_REPLICAS = hrrl_pkg::MAX_REPLICAS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [63:0] point_hash,
    input  wire logic [31:0] node_id,
    input  wire logic [3:0]  replica_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result_node,
    output logic [1:0]       status,
    output logic             last
);
    import hrrl_pkg::*;

    logic q_valid, q_take;
    cmd_t q_cmd;

    hrrl_front #(.MAX_REPLICAS(MAX_REPLICAS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .point_hash(point_hash), .node_id(node_id),
        .replica_count(replica_count), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd));

    hrrl_back #(.RING_SLOTS(RING_SLOTS), .MAX_REPLICAS(MAX_REPLICAS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
        .out_valid(out_valid), .out_stall(out_stall), .result_node(result_node),
        .status(status), .last(last));
endmodule
`default_nettype wire

@@ hdl/hrrl_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module hrrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Read first (old data on a write), read registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ hdl/hrrl_front.sv @@
// Front end: accepts transactions, normalizes them and queues them.
`timescale 1ns / 1ps
`default_nettype none
module hrrl_front #(
    parameter int MAX_REPLICAS = hrrl_pkg::MAX_REPLICAS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    kind,
    input  wire logic [63:0]   point_hash,
    input  wire logic [31:0]   node_id,
    input  wire logic [3:0]    replica_count,
    output logic               q_valid,
    input  wire logic          q_take,
    output hrrl_pkg::cmd_t     q_cmd
);
    import hrrl_pkg::*;
    `include "hash_ring_replica_lookup_unit_assert.svh"

    hrrl_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rp_reg, rp_next, wp_reg, wp_next;
    logic       push;
    logic [3:0] rc;
    hrrl_pkg::cmd_t cmd_in;

    // Clamp the replica count to the supported range.
    always_comb
    begin
        rc = replica_count;
        if (rc == 4'd0)
        begin
            rc = 4'd1;
        end
        if (32'(rc) > MAX_REPLICAS)
        begin
            rc = 4'(MAX_REPLICAS > 15 ? 15 : MAX_REPLICAS);
        end
        cmd_in.kind          = kind;
        cmd_in.point_hash    = point_hash;
        cmd_in.node_id       = node_id;
        cmd_in.replica_count = rc;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rp_reg];

    // Two-entry queue pointers.
    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(q_take);
        rp_next  = rp_reg ^ q_take;
        wp_next  = wp_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rp_reg  <= rp_next;
            wp_reg  <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cmd_in;
        end
    end

    `HR_ASSERT_IMP(a_take_valid, clk, rst_n, q_take, q_valid)
    `HR_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `HR_ASSERT_NXT(a_full_after, clk, rst_n, cnt_reg == 2'd1 && push && !q_take, cnt_reg == 2'd2)
endmodule
`default_nettype wire

@@ hdl/hrrl_back.sv @@
// Back end: executes insert, remove and lookup on the sorted ring.
`timescale 1ns / 1ps
`default_nettype none
module hrrl_back #(
    parameter int RING_SLOTS   = hrrl_pkg::RING_SLOTS_DEF,
    parameter int MAX_REPLICAS = hrrl_pkg::MAX_REPLICAS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_take,
    input  hrrl_pkg::cmd_t     q_cmd,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [31:0]        result_node,
    output logic [1:0]         status,
    output logic               last
);
    import hrrl_pkg::*;
    `include "hash_ring_replica_lookup_unit_assert.svh"

    localparam int AW = $clog2(RING_SLOTS);
    localparam int FW = $clog2(RING_SLOTS + 1);
    localparam int RW = $clog2(MAX_REPLICAS + 1);
    localparam int SW = (RW > 4) ? RW : 4;
    localparam int NW = $clog2(MAX_REPLICAS > 1 ? MAX_REPLICAS : 2);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;  // search read issued
    localparam logic [3:0] S_SCMP = 4'd2;  // search compare
    localparam logic [3:0] S_SHRD = 4'd3;  // shift read
    localparam logic [3:0] S_SHWR = 4'd4;  // shift write
    localparam logic [3:0] S_PUT  = 4'd5;  // insert new point
    localparam logic [3:0] S_RMRD = 4'd6;  // remove read
    localparam logic [3:0] S_RMCK = 4'd7;  // remove check/write
    localparam logic [3:0] S_LKRD = 4'd8;  // lookup read
    localparam logic [3:0] S_LKCK = 4'd9;  // lookup check
    localparam logic [3:0] S_OUT  = 4'd10; // emit result
    localparam logic [3:0] S_WAIT = 4'd11; // wait for write to settle
    localparam logic [3:0] S_LEM  = 4'd12; // pick next collected lookup node

    logic [3:0]    st_reg, st_next;
    hrrl_pkg::cmd_t cmd_reg, cmd_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] i_reg, i_next;      // scan index
    logic [FW-1:0] j_reg, j_next;      // write index / shift index
    logic [FW-1:0] steps_reg, steps_next;
    logic          hit_reg, hit_next;
    logic [31:0]   found_reg [MAX_REPLICAS];
    logic [SW-1:0] nf_reg, nf_next;
    logic [SW-1:0] e_reg, e_next;      // emit index into the found list
    logic          add_found;
    logic          o_valid_reg, o_valid_next;
    logic [31:0]   o_node_reg, o_node_next;
    logic [1:0]    o_st_reg, o_st_next;
    logic          o_last_reg, o_last_next;
    logic [31:0]   r_node_reg, r_node_next;   // result waiting for the output register
    logic [1:0]    r_st_reg, r_st_next;
    logic          r_last_reg, r_last_next;
    logic          after_out_reg, after_out_next;  // more lookup results follow

    logic          we;
    logic [AW-1:0] addr;
    logic [63:0]   wh, rh;
    logic [31:0]   wo, ro;
    logic          seen;

    hrrl_ram #(.WIDTH(64), .DEPTH(RING_SLOTS)) u_hash (
        .clk(clk), .we(we), .addr(addr), .wdata(wh), .rdata(rh));
    hrrl_ram #(.WIDTH(32), .DEPTH(RING_SLOTS)) u_owner (
        .clk(clk), .we(we), .addr(addr), .wdata(wo), .rdata(ro));

    // Compare the current owner against already collected nodes.
    always_comb
    begin
        seen = 1'b0;
        for (int k = 0; k < MAX_REPLICAS; k++)
        begin
            if (SW'(k) < nf_reg && found_reg[k] == ro)
            begin
                seen = 1'b1;
            end
        end
    end

    // Main sequencer.
    always_comb
    begin
        st_next        = st_reg;
        cmd_next       = cmd_reg;
        fill_next      = fill_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        steps_next     = steps_reg;
        hit_next       = hit_reg;
        nf_next        = nf_reg;
        e_next         = e_reg;
        add_found      = 1'b0;
        o_valid_next   = o_valid_reg;
        o_node_next    = o_node_reg;
        o_st_next      = o_st_reg;
        o_last_next    = o_last_reg;
        r_node_next    = r_node_reg;
        r_st_next      = r_st_reg;
        r_last_next    = r_last_reg;
        after_out_next = after_out_reg;
        q_take         = 1'b0;
        we             = 1'b0;
        addr           = i_reg[AW-1:0];
        wh             = rh;
        wo             = ro;
        if (o_valid_reg && !out_stall)
        begin
            o_valid_next = 1'b0;
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take   = 1'b1;
                    cmd_next = q_cmd;
                    i_next   = '0;
                    j_next   = '0;
                    hit_next = 1'b0;
                    nf_next  = '0;
                    e_next   = '0;
                    steps_next = '0;
                    unique case (q_cmd.kind)
                        KIND_INSERT, KIND_LOOKUP:
                        begin
                            st_next = S_SRD;
                        end
                        KIND_REMOVE:
                        begin
                            st_next = S_RMRD;
                        end
                        default:
                        begin
                            r_node_next    = '0;
                            r_st_next      = ST_OK;
                            r_last_next    = 1'b1;
                            after_out_next = 1'b0;
                            st_next        = S_OUT;
                        end
                    endcase
                end
            end
            S_SRD:
            begin
                // Scan for first slot not below (insert) / strictly above (lookup) the key.
                if (i_reg >= fill_reg)
                begin
                    st_next = S_SCMP;
                end
                else
                begin
                    st_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (i_reg < fill_reg &&
                    ((cmd_reg.kind == KIND_INSERT) ? (rh < cmd_reg.point_hash)
                                                   : (rh <= cmd_reg.point_hash)))
                begin
                    i_next  = i_reg + 1'b1;
                    st_next = S_SRD;
                end
                else if (cmd_reg.kind == KIND_LOOKUP)
                begin
                    if (fill_reg == '0)
                    begin
                        r_node_next    = '0;
                        r_st_next      = ST_EMPTY;
                        r_last_next    = 1'b1;
                        after_out_next = 1'b0;
                        st_next        = S_OUT;
                    end
                    else
                    begin
                        if (i_reg >= fill_reg)
                        begin
                            i_next = '0;
                        end
                        st_next = S_LKRD;
                    end
                end
                else if (i_reg < fill_reg && rh == cmd_reg.point_hash)
                begin
                    we             = 1'b1;
                    wh             = cmd_reg.point_hash;
                    wo             = cmd_reg.node_id;
                    r_node_next    = '0;
                    r_st_next      = ST_OK;
                    r_last_next    = 1'b1;
                    after_out_next = 1'b0;
                    st_next        = S_OUT;
                end
                else if (32'(fill_reg) >= RING_SLOTS)
                begin
                    r_node_next    = '0;
                    r_st_next      = ST_FULL;
                    r_last_next    = 1'b1;
                    after_out_next = 1'b0;
                    st_next        = S_OUT;
                end
                else
                begin
                    j_next  = fill_reg;
                    st_next = (fill_reg == i_reg) ? S_PUT : S_SHRD;
                end
            end
            S_SHRD:
            begin
                addr    = AW'(j_reg - 1'b1);
                st_next = S_SHWR;
            end
            S_SHWR:
            begin
                we     = 1'b1;
                addr   = j_reg[AW-1:0];
                j_next = j_reg - 1'b1;
                st_next = (j_reg - 1'b1 == i_reg) ? S_PUT : S_SHRD;
            end
            S_PUT:
            begin
                we             = 1'b1;
                wh             = cmd_reg.point_hash;
                wo             = cmd_reg.node_id;
                fill_next      = fill_reg + 1'b1;
                r_node_next    = '0;
                r_st_next      = ST_OK;
                r_last_next    = 1'b1;
                after_out_next = 1'b0;
                st_next        = S_OUT;
            end
            S_RMRD:
            begin
                if (i_reg >= fill_reg)
                begin
                    fill_next      = j_reg;
                    r_node_next    = '0;
                    r_st_next      = hit_reg ? ST_OK : ST_ABSENT;
                    r_last_next    = 1'b1;
                    after_out_next = 1'b0;
                    st_next        = S_OUT;
                end
                else
                begin
                    st_next = S_RMCK;
                end
            end
            S_RMCK:
            begin
                i_next = i_reg + 1'b1;
                if (ro == cmd_reg.node_id)
                begin
                    hit_next = 1'b1;
                    st_next  = S_RMRD;
                end
                else
                begin
                    we      = 1'b1;
                    addr    = j_reg[AW-1:0];
                    j_next  = j_reg + 1'b1;
                    st_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                st_next = S_RMRD;
            end
            S_LKRD:
            begin
                st_next = S_LKCK;
            end
            S_LKCK:
            begin
                steps_next = steps_reg + 1'b1;
                i_next     = (i_reg + 1'b1 >= fill_reg) ? '0 : i_reg + 1'b1;
                if (!seen)
                begin
                    add_found = 1'b1;
                    nf_next   = nf_reg + 1'b1;
                end
                // The walk ends when enough distinct nodes are found or one lap is done.
                if ((!seen && nf_reg + 1'b1 == SW'(cmd_reg.replica_count)) ||
                    (steps_reg + 1'b1 == fill_reg))
                begin
                    e_next  = '0;
                    st_next = S_LEM;
                end
                else
                begin
                    st_next = S_LKRD;
                end
            end
            S_LEM:
            begin
                // Hand out the collected nodes in order; the final one carries last.
                r_node_next    = found_reg[e_reg[NW-1:0]];
                r_st_next      = ST_OK;
                r_last_next    = (e_reg + 1'b1 == nf_reg);
                after_out_next = (e_reg + 1'b1 != nf_reg);
                e_next         = e_reg + 1'b1;
                st_next        = S_OUT;
            end
            S_OUT:
            begin
                if (!o_valid_reg || !out_stall)
                begin
                    o_valid_next = 1'b1;
                    o_node_next  = r_node_reg;
                    o_st_next    = r_st_reg;
                    o_last_next  = r_last_reg;
                    st_next      = after_out_reg ? S_LEM : S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            fill_reg      <= '0;
            o_valid_reg   <= 1'b0;
            after_out_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            fill_reg      <= fill_next;
            o_valid_reg   <= o_valid_next;
            after_out_reg <= after_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        steps_reg  <= steps_next;
        hit_reg    <= hit_next;
        nf_reg     <= nf_next;
        e_reg      <= e_next;
        o_node_reg <= o_node_next;
        o_st_reg   <= o_st_next;
        o_last_reg <= o_last_next;
        r_node_reg <= r_node_next;
        r_st_reg   <= r_st_next;
        r_last_reg <= r_last_next;
        if (add_found && nf_reg < SW'(MAX_REPLICAS))
        begin
            found_reg[nf_reg[NW-1:0]] <= ro;
        end
    end

    assign out_valid   = o_valid_reg;
    assign result_node = o_node_reg;
    assign status      = o_st_reg;
    assign last        = o_last_reg;

    `HR_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, 32'(fill_reg) <= RING_SLOTS)
    `HR_ASSERT_IMP(a_take_idle, clk, rst_n, q_take, st_reg == S_IDLE)
    `HR_ASSERT_IMP(a_nonok_zero, clk, rst_n, out_valid && status != ST_OK, result_node == '0)
endmodule
`default_nettype wire
